[rtl/i2c_light_sensor_master_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the light sensor bus master
// Concurrent checks clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef I2C_LIGHT_SENSOR_MASTER_UNIT_MACROS_SVH
`define I2C_LIGHT_SENSOR_MASTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILSM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ilsm check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ILSM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ilsm check failed in the next cycle");

`endif

[rtl/ilsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsm_pkg
// Shared widths, codes, reset values and types of the light sensor bus master.
// ----------------------------------------------------------------------------
package ilsm_pkg;

   localparam int OPCODE_W = 2;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int WORD_W   = 16;
   localparam int ADDR7_W  = 7;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register i sits at byte address 4*i.
   localparam int REG_INDEX_W = 2;
   localparam logic [REG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
   localparam logic [REG_INDEX_W-1:0] REG_DELAY_TICKS    = 2'd1;
   localparam logic [REG_INDEX_W-1:0] REG_POWER_ON_CMD   = 2'd2;
   localparam logic [REG_INDEX_W-1:0] REG_MODE_CMD       = 2'd3;

   localparam logic [OPCODE_W-1:0] OP_NONE    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SEND    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ    = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_MEASURE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BUS_BUSY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_ACK   = 2'd2;

   localparam logic [ADDR7_W-1:0] RST_DEVICE_ADDRESS = 7'd35;
   localparam logic [BYTE_W-1:0]  RST_DELAY_TICKS    = 8'd10;
   localparam logic [BYTE_W-1:0]  RST_POWER_ON_CMD   = 8'd1;
   localparam logic [BYTE_W-1:0]  RST_MODE_CMD       = 8'd32;

   // lux = floor(raw * 5 / 6) = (raw * LUX_MULT) >> LUX_SHIFT, exact for 16-bit raw.
   localparam int LUX_SHIFT = 19;
   localparam int LUX_MULT_W = 19;
   localparam logic [LUX_MULT_W-1:0] LUX_MULT = 19'd436907;

   typedef struct packed {
      logic [ADDR7_W-1:0] device_address;
      logic [BYTE_W-1:0]  delay_ticks;
      logic [BYTE_W-1:0]  power_on_command;
      logic [BYTE_W-1:0]  mode_command;
   } cfg_type;

   // One classified bus tick waiting for the engine.
   typedef struct packed {
      logic                start_req;
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   command_byte;
      logic                sda_in;
      logic                bus_free;
   } queue_entry_type;

endpackage

[rtl/ilsm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsm_if
// Valid/ready channels of the light sensor bus master: tick beats in, results out.
// ----------------------------------------------------------------------------
interface ilsm_req_if import ilsm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   command_byte;
   logic                sda_in;
   logic                bus_free;

   modport source (output valid, opcode, command_byte, sda_in, bus_free, input ready);
   modport sink   (input valid, opcode, command_byte, sda_in, bus_free, output ready);
endinterface

interface ilsm_rsp_if import ilsm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                scl_drive;
   logic                sda_drive;
   logic                ready_res;
   logic                done_res;
   logic [STATUS_W-1:0] status_code;
   logic [WORD_W-1:0]   raw_value;
   logic [WORD_W-1:0]   lux_value;

   modport source (output valid, scl_drive, sda_drive, ready_res, done_res, status_code,
                   raw_value, lux_value, input ready);
   modport sink   (input valid, scl_drive, sda_drive, ready_res, done_res, status_code,
                   raw_value, lux_value, output ready);
endinterface

[rtl/ilsm_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsm_csr
// APB-style register file holding the address, delay and command registers.
// ----------------------------------------------------------------------------
module ilsm_csr
   import ilsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   write_en;
   logic [REG_INDEX_W-1:0] reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_DEVICE_ADDRESS: cfg_in.device_address   = pwdata[ADDR7_W-1:0];
            REG_DELAY_TICKS:    cfg_in.delay_ticks      = pwdata[BYTE_W-1:0];
            REG_POWER_ON_CMD:   cfg_in.power_on_command = pwdata[BYTE_W-1:0];
            REG_MODE_CMD:       cfg_in.mode_command     = pwdata[BYTE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DEVICE_ADDRESS: prdata = CSR_DATA_W'(cfg_ff.device_address);
         REG_DELAY_TICKS:    prdata = CSR_DATA_W'(cfg_ff.delay_ticks);
         REG_POWER_ON_CMD:   prdata = CSR_DATA_W'(cfg_ff.power_on_command);
         REG_MODE_CMD:       prdata = CSR_DATA_W'(cfg_ff.mode_command);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address   <= RST_DEVICE_ADDRESS;
         cfg_ff.delay_ticks      <= RST_DELAY_TICKS;
         cfg_ff.power_on_command <= RST_POWER_ON_CMD;
         cfg_ff.mode_command     <= RST_MODE_CMD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/ilsm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsm_front
// Accepts tick beats, marks those that carry an opcode, and queues them.
// ----------------------------------------------------------------------------
module ilsm_front
   import ilsm_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic            clock,
   input  logic            reset,
   ilsm_req_if.sink        req_chan,
   output logic            head_valid,
   output queue_entry_type head,
   input  logic            head_take
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  slot_ff [DEPTH];
   queue_entry_type  slot_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign req_chan.ready = (count_ff != CNT_W'(DEPTH));
   assign push = req_chan.valid && req_chan.ready;
   assign pop  = head_take && head_valid;

   always_comb begin
      slot_in.start_req    = (req_chan.opcode != OP_NONE);
      slot_in.opcode       = req_chan.opcode;
      slot_in.command_byte = req_chan.command_byte;
      slot_in.sda_in       = req_chan.sda_in;
      slot_in.bus_free     = req_chan.bus_free;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

endmodule

[rtl/ilsm_engine.sv]
`timescale 1ns / 1ps
`include "i2c_light_sensor_master_unit_macros.svh"
// ----------------------------------------------------------------------------
// ilsm_engine
// Bus sequencer: advances start, byte, acknowledge and stop steps one tick a beat.
// ----------------------------------------------------------------------------
module ilsm_engine
   import ilsm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            head_valid,
   input  queue_entry_type head,
   output logic            head_take,
   ilsm_rsp_if.source      rsp_chan
);

   localparam logic [4:0] PH_IDLE         = 5'd0;
   localparam logic [4:0] PH_START1       = 5'd1;
   localparam logic [4:0] PH_START2       = 5'd2;
   localparam logic [4:0] PH_TX_SETUP     = 5'd3;
   localparam logic [4:0] PH_TX_HIGH      = 5'd4;
   localparam logic [4:0] PH_TX_LOW       = 5'd5;
   localparam logic [4:0] PH_ACK_SETUP    = 5'd6;
   localparam logic [4:0] PH_ACK_HIGH     = 5'd7;
   localparam logic [4:0] PH_ACK_LOW_OK   = 5'd8;
   localparam logic [4:0] PH_ACK_LOW_FAIL = 5'd9;
   localparam logic [4:0] PH_RX_SETUP     = 5'd10;
   localparam logic [4:0] PH_RX_HIGH      = 5'd11;
   localparam logic [4:0] PH_RX_LOW       = 5'd12;
   localparam logic [4:0] PH_MACK1        = 5'd13;
   localparam logic [4:0] PH_MACK2        = 5'd14;
   localparam logic [4:0] PH_MACK3        = 5'd15;
   localparam logic [4:0] PH_MACK4        = 5'd16;
   localparam logic [4:0] PH_STOP         = 5'd17;

   localparam int PROD_W = WORD_W + LUX_MULT_W;

   typedef struct packed {
      logic [4:0]          phase;
      logic [BYTE_W-1:0]   tick;
      logic [BYTE_W-1:0]   shift_byte;
      logic [2:0]          bit_pos;
      logic [1:0]          stage;
      logic [BYTE_W-1:0]   high_byte;
      logic [WORD_W-1:0]   result_word;
      logic [STATUS_W-1:0] last_status;
      logic                scl;
      logic                sda;
      logic [OPCODE_W-1:0] op_kind;
      logic [BYTE_W-1:0]   cmd_latch;
      logic [1:0]          byte_index;
      logic                done;
   } eng_state_type;

   eng_state_type       state_ff, state_in;
   logic [WORD_W-1:0]   lux_ff, lux_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                advance;
   logic [BYTE_W-1:0]   span;
   logic [BYTE_W-1:0]   tick_next;
   logic [PROD_W-1:0]   lux_product;

   function automatic eng_state_type enter_phase(eng_state_type s, logic [4:0] ph,
                                                 logic scl, logic sda);
      s.phase = ph;
      s.tick  = '0;
      s.scl   = scl;
      s.sda   = sda;
      return s;
   endfunction

   function automatic eng_state_type finish(eng_state_type s);
      s.phase = PH_IDLE;
      s.tick  = '0;
      s.done  = 1'b1;
      return s;
   endfunction

   function automatic logic stage_is_read(eng_state_type s);
      return (s.op_kind == OP_READ) || (s.op_kind == OP_MEASURE && s.stage == 2'd2);
   endfunction

   function automatic logic [BYTE_W-1:0] stage_command(eng_state_type s, cfg_type c);
      if (s.op_kind == OP_SEND) begin
         return s.cmd_latch;
      end
      return (s.stage == 2'd0) ? c.power_on_command : c.mode_command;
   endfunction

   // A busy bus fails every remaining measure stage on the same sample.
   function automatic eng_state_type try_start(eng_state_type s, logic bus_free);
      if (bus_free) begin
         s.byte_index = 2'd0;
         s = enter_phase(s, PH_START1, 1'b1, 1'b1);
      end else begin
         if (s.last_status == ST_OK) begin
            s.last_status = ST_BUS_BUSY;
         end
         if (s.op_kind == OP_MEASURE) begin
            s.stage = 2'd2;
         end
         s = finish(s);
      end
      return s;
   endfunction

   function automatic eng_state_type load_tx(eng_state_type s, logic [BYTE_W-1:0] b);
      s.shift_byte = b;
      s.bit_pos    = 3'd7;
      s = enter_phase(s, PH_TX_SETUP, 1'b0, b[BYTE_W-1]);
      return s;
   endfunction

   assign advance   = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign head_take = advance;
   assign span      = (cfg.delay_ticks == '0) ? 8'd1 : cfg.delay_ticks;
   assign tick_next = state_ff.tick + 8'd1;

   // The finished word is the high byte and the byte just shifted in.
   assign lux_product = {state_ff.high_byte, state_ff.shift_byte} * LUX_MULT;

   always_comb begin
      state_in = state_ff;
      lux_in   = lux_ff;
      if (advance) begin
         state_in.done = 1'b0;
         if (state_ff.phase == PH_IDLE) begin
            if (head.start_req) begin
               state_in.op_kind     = head.opcode;
               state_in.cmd_latch   = head.command_byte;
               state_in.stage       = 2'd0;
               state_in.last_status = ST_OK;
               state_in = try_start(state_in, head.bus_free);
            end
         end else begin
            state_in.tick = tick_next;
            if (tick_next >= span) begin
               unique case (state_ff.phase)
                  PH_START1: state_in = enter_phase(state_in, PH_START2, 1'b1, 1'b0);
                  PH_START2: begin
                     state_in = load_tx(state_in,
                                        {cfg.device_address, stage_is_read(state_in)});
                  end
                  PH_TX_SETUP: begin
                     state_in = enter_phase(state_in, PH_TX_HIGH, 1'b1, state_in.sda);
                  end
                  PH_TX_HIGH: begin
                     state_in = enter_phase(state_in, PH_TX_LOW, 1'b0, state_in.sda);
                  end
                  PH_TX_LOW: begin
                     if (state_in.bit_pos != 3'd0) begin
                        state_in.bit_pos = state_in.bit_pos - 3'd1;
                        state_in = enter_phase(state_in, PH_TX_SETUP, 1'b0,
                                               state_in.shift_byte[state_in.bit_pos]);
                     end else begin
                        state_in = enter_phase(state_in, PH_ACK_SETUP, 1'b0, 1'b1);
                     end
                  end
                  PH_ACK_SETUP: begin
                     state_in = enter_phase(state_in, PH_ACK_HIGH, 1'b1, 1'b1);
                  end
                  PH_ACK_HIGH: begin
                     state_in = enter_phase(state_in,
                                            head.sda_in ? PH_ACK_LOW_FAIL : PH_ACK_LOW_OK,
                                            1'b0, 1'b1);
                  end
                  PH_ACK_LOW_FAIL: begin
                     if (state_in.last_status == ST_OK) begin
                        state_in.last_status = ST_NO_ACK;
                     end
                     state_in = enter_phase(state_in, PH_STOP, 1'b1, 1'b0);
                  end
                  PH_ACK_LOW_OK: begin
                     if (state_in.byte_index == 2'd0) begin
                        state_in.byte_index = 2'd1;
                        if (stage_is_read(state_in)) begin
                           state_in.bit_pos = 3'd7;
                           state_in = enter_phase(state_in, PH_RX_SETUP, 1'b0, 1'b1);
                        end else begin
                           state_in = load_tx(state_in, stage_command(state_in, cfg));
                        end
                     end else begin
                        state_in = enter_phase(state_in, PH_STOP, 1'b1, 1'b0);
                     end
                  end
                  PH_RX_SETUP: begin
                     state_in = enter_phase(state_in, PH_RX_HIGH, 1'b1, 1'b1);
                  end
                  PH_RX_HIGH: begin
                     state_in.shift_byte[state_in.bit_pos] = head.sda_in;
                     state_in = enter_phase(state_in, PH_RX_LOW, 1'b0, 1'b1);
                  end
                  PH_RX_LOW: begin
                     if (state_in.bit_pos != 3'd0) begin
                        state_in.bit_pos = state_in.bit_pos - 3'd1;
                        state_in = enter_phase(state_in, PH_RX_HIGH, 1'b1, 1'b1);
                     end else if (state_in.byte_index == 2'd1) begin
                        state_in.high_byte  = state_in.shift_byte;
                        state_in.byte_index = 2'd2;
                        state_in = enter_phase(state_in, PH_MACK1, 1'b0, 1'b1);
                     end else begin
                        state_in.result_word = {state_in.high_byte, state_in.shift_byte};
                        lux_in = lux_product[LUX_SHIFT +: WORD_W];
                        state_in = enter_phase(state_in, PH_STOP, 1'b1, 1'b0);
                     end
                  end
                  PH_MACK1: state_in = enter_phase(state_in, PH_MACK2, 1'b0, 1'b0);
                  PH_MACK2: state_in = enter_phase(state_in, PH_MACK3, 1'b1, 1'b0);
                  PH_MACK3: state_in = enter_phase(state_in, PH_MACK4, 1'b0, 1'b0);
                  PH_MACK4: begin
                     state_in.bit_pos = 3'd7;
                     state_in = enter_phase(state_in, PH_RX_SETUP, 1'b0, 1'b1);
                  end
                  PH_STOP: begin
                     state_in.sda = 1'b1;
                     if (state_in.op_kind == OP_MEASURE && state_in.stage < 2'd2) begin
                        state_in.stage = state_in.stage + 2'd1;
                        state_in = try_start(state_in, head.bus_free);
                     end else begin
                        state_in = finish(state_in);
                     end
                  end
                  default: state_in = finish(state_in);
               endcase
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PH_IDLE;
         state_ff.tick        <= '0;
         state_ff.shift_byte  <= '0;
         state_ff.bit_pos     <= 3'd7;
         state_ff.stage       <= 2'd0;
         state_ff.high_byte   <= '0;
         state_ff.result_word <= '0;
         state_ff.last_status <= ST_OK;
         state_ff.scl         <= 1'b1;
         state_ff.sda         <= 1'b1;
         state_ff.op_kind     <= OP_NONE;
         state_ff.cmd_latch   <= '0;
         state_ff.byte_index  <= 2'd0;
         state_ff.done        <= 1'b0;
         lux_ff               <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lux_ff       <= lux_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.scl_drive   = state_ff.scl;
   assign rsp_chan.sda_drive   = state_ff.sda;
   assign rsp_chan.ready_res   = (state_ff.phase == PH_IDLE);
   assign rsp_chan.done_res    = state_ff.done;
   assign rsp_chan.status_code = state_ff.last_status;
   assign rsp_chan.raw_value   = state_ff.result_word;
   assign rsp_chan.lux_value   = lux_ff;

   // A stalled result must not let the bus sequence move on.
   `ILSM_ASSERT_NEXT(a_stall_holds_state, !advance, $stable(state_ff) && $stable(lux_ff))
   // A start on a taken bus finishes at once with the busy code.
   `ILSM_ASSERT_NEXT(a_busy_start_finishes,
      advance && state_ff.phase == PH_IDLE && head.start_req && !head.bus_free,
      state_ff.done && state_ff.last_status == ST_BUS_BUSY && state_ff.phase == PH_IDLE)
   // Only the measure operation ever steps through stages.
   `ILSM_ASSERT_NOW(a_stage_only_measure,
      state_ff.phase != PH_IDLE && state_ff.op_kind != OP_MEASURE,
      state_ff.stage == 2'd0)

endmodule

[rtl/i2c_light_sensor_master_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_light_sensor_master_unit
// Open-drain bus master that writes commands to and reads words from a light sensor.
// ----------------------------------------------------------------------------
//  channel   direction  content of one beat
//  req_chan  in         opcode, command byte, sampled data line, bus free flag
//  rsp_chan  out        pin drives, idle and done flags, status, raw and lux words
//  apb       in/out     device address, delay ticks, power-on and mode commands
//
// One beat is one bus tick; unless the queue is empty or results stall, the sequencer
// takes one beat every cycle; each passes the queue, then the sequencer registers.
// A queue of QUEUE_DEPTH beats sits in front of the sequencer and fills while the
// result side stalls; req_chan.ready falls only once it is full.
// Synchronous reset returns the registers to their defaults, empties the queue and
// leaves the sequencer idle with both lines released.
// ----------------------------------------------------------------------------
module i2c_light_sensor_master_unit
   import ilsm_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   ilsm_req_if.sink              req_chan,
   ilsm_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type         cfg;
   logic            head_valid;
   queue_entry_type head;
   logic            head_take;

   ilsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ilsm_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take)
   );

   ilsm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take),
      .rsp_chan   (rsp_chan)
   );

endmodule
